[rtl/key_and_valve_input_qualifier_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the key and valve input qualifier
// Concurrent checks that are compiled out when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef KEY_AND_VALVE_INPUT_QUALIFIER_UNIT_DEFINES_SVH
`define KEY_AND_VALVE_INPUT_QUALIFIER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Implication property checked on every clock edge out of reset
`define KVQ_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("kvq assertion failed");

// Condition that must never be true out of reset
`define KVQ_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("kvq forbidden condition seen");

`else

`define KVQ_ASSERT(lbl, clk, rst_n, prop)
`define KVQ_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[rtl/kvq_pkg.sv]
// ---------------------------------------------------------------------------
// kvq_pkg
// Shared types, register indexes and reset values of the input qualifier.
// ---------------------------------------------------------------------------
package kvq_pkg;

	localparam int TICK_W         = 16;
	localparam int CFG_IDX_W      = 8;
	localparam int COUNTER_BITS_D = 16;

	localparam logic [TICK_W-1:0] FILTER_TICKS_RST = 16'd5;
	localparam logic [TICK_W-1:0] LONG_TICKS_RST   = 16'd100;
	localparam logic [TICK_W-1:0] OPEN_TICKS_RST   = 16'd10;
	localparam logic [TICK_W-1:0] CLOSE_TICKS_RST  = 16'd10;

	localparam logic [CFG_IDX_W-1:0] REG_FILTER_TICKS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPEN_TICKS   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLOSE_TICKS  = 8'd3;

	typedef enum logic [1:0] {
		KEY_UP   = 2'd0,
		KEY_DOWN = 2'd1,
		KEY_HOLD = 2'd2
	} key_mode_t;

	typedef enum logic [1:0] {
		VALVE_NULL  = 2'd0,
		VALVE_OPEN  = 2'd1,
		VALVE_CLOSE = 2'd2
	} valve_mode_t;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2
	} valve_cmd_t;

	typedef struct packed {
		key_mode_t mode;
		logic      entered_down;
	} key_result_t;

endpackage

[rtl/kvq_key_filter.sv]
// ---------------------------------------------------------------------------
// kvq_key_filter
// Debounce and long-press qualification of one key with a saturating counter.
// ---------------------------------------------------------------------------
module kvq_key_filter
	import kvq_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_D
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              pressed,
	input  logic [TICK_W-1:0] filter_ticks,
	input  logic [TICK_W-1:0] long_ticks,
	output key_result_t       result
);

	localparam int CMP_W = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;

	key_mode_t               mode_q, mode_d;
	logic [COUNTER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
	logic [TICK_W-1:0]       limit;
	logic                    past;

	assign cnt_inc = (cnt_q == {COUNTER_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	assign limit   = (mode_q == KEY_DOWN) ? long_ticks : filter_ticks;
	// compare the old count before it advances
	assign past    = CMP_W'(cnt_q) > CMP_W'(limit);

	always_comb begin
		mode_d              = mode_q;
		cnt_d               = cnt_q;
		result.entered_down = 1'b0;
		if (!pressed) begin
			mode_d = KEY_UP;
			cnt_d  = '0;
		end else begin
			unique case (mode_q)
				KEY_UP: begin
					cnt_d = cnt_inc;
					if (past) begin
						mode_d              = KEY_DOWN;
						result.entered_down = 1'b1;
					end
				end
				KEY_DOWN: begin
					cnt_d = cnt_inc;
					if (past) begin
						mode_d = KEY_HOLD;
					end
				end
				default: begin
					// hold: stop counting
					mode_d = mode_q;
				end
			endcase
		end
		result.mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= KEY_UP;
			cnt_q  <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

[rtl/key_and_valve_input_qualifier_unit.sv]
// ---------------------------------------------------------------------------
// key_and_valve_input_qualifier_unit
// Qualifies two keys and a valve pressure signal, one sampling tick per
// transaction, and issues key status, valve status, valve drive and beep.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one sampling tick: both key
//   levels, the valve open signal and the machine idle flag. Each input
//   transaction yields exactly one output transaction (out_valid/out_ready)
//   with both key states, the valve state, the valve drive and the beep.
//   An accepted tick sits in the input register while the qualifier logic
//   settles; the result register then takes it and raises out_valid.
//   Throughput is 1 tick per cycle while the receiver keeps up; the key
//   counters, the valve counters and their compares settle in the qualifier stage.
//   When the receiver stalls, the result register holds and the input
//   register keeps accepting until it is full too; in_ready then drops.
//   Configuration writes (cfg_valid/cfg_ready, always ready) set the four
//   thresholds; indexes beyond the register list are dropped. Write them
//   only while no tick is in flight.
//   Reset clears both stages, sets keys to up, valve to unsettled, counters
//   to zero and thresholds to their defaults (5, 100, 10, 10).
// ---------------------------------------------------------------------------
`include "key_and_valve_input_qualifier_unit_defines.svh"

module key_and_valve_input_qualifier_unit
	import kvq_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_D
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 ele_pressed,
	input  logic                 res_pressed,
	input  logic                 valve_open_signal,
	input  logic                 machine_idle,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           ele_key_status,
	output logic [1:0]           res_key_status,
	output logic [1:0]           valve_status,
	output logic [1:0]           valve_command,
	output logic                 beep_request,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);

	localparam int CMP_W = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;

	logic [TICK_W-1:0] filter_ticks_q, long_ticks_q, open_ticks_q, close_ticks_q;

	logic v_s1, ele_s1, res_s1, open_s1, idle_s1;
	logic advance;

	key_result_t ele_res, res_res;

	valve_mode_t             valve_q, valve_d;
	valve_cmd_t              cmd_d;
	logic [COUNTER_BITS-1:0] open_cnt_q, open_cnt_d, close_cnt_q, close_cnt_d;
	logic [COUNTER_BITS-1:0] open_inc, close_inc;
	logic                    open_past, close_past;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_ticks_q <= FILTER_TICKS_RST;
			long_ticks_q   <= LONG_TICKS_RST;
			open_ticks_q   <= OPEN_TICKS_RST;
			close_ticks_q  <= CLOSE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FILTER_TICKS: filter_ticks_q <= cfg_data;
				REG_LONG_TICKS:   long_ticks_q   <= cfg_data;
				REG_OPEN_TICKS:   open_ticks_q   <= cfg_data;
				REG_CLOSE_TICKS:  close_ticks_q  <= cfg_data;
				default: begin
					// drop writes beyond the register list
					filter_ticks_q <= filter_ticks_q;
				end
			endcase
		end
	end

	// input register and pipeline control
	assign advance  = v_s1 && (!out_valid || out_ready);
	assign in_ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= (in_valid && in_ready) || (v_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ele_s1  <= ele_pressed;
			res_s1  <= res_pressed;
			open_s1 <= valve_open_signal;
			idle_s1 <= machine_idle;
		end
	end

	// key qualifiers
	kvq_key_filter #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_ele_key (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.pressed      (ele_s1),
		.filter_ticks (filter_ticks_q),
		.long_ticks   (long_ticks_q),
		.result       (ele_res)
	);

	kvq_key_filter #(
		.COUNTER_BITS(COUNTER_BITS)
	) u_res_key (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.pressed      (res_s1),
		.filter_ticks (filter_ticks_q),
		.long_ticks   (long_ticks_q),
		.result       (res_res)
	);

	// valve qualifier
	assign open_inc   = (open_cnt_q == {COUNTER_BITS{1'b1}}) ? open_cnt_q : open_cnt_q + 1'b1;
	assign close_inc  = (close_cnt_q == {COUNTER_BITS{1'b1}}) ? close_cnt_q
	                                                           : close_cnt_q + 1'b1;
	assign open_past  = CMP_W'(open_cnt_q) > CMP_W'(open_ticks_q);
	assign close_past = CMP_W'(close_cnt_q) > CMP_W'(close_ticks_q);

	always_comb begin
		valve_d     = VALVE_NULL;
		cmd_d       = CMD_NONE;
		open_cnt_d  = open_cnt_q;
		close_cnt_d = close_cnt_q;
		if (open_s1) begin
			close_cnt_d = '0;
			if (valve_q == VALVE_OPEN) begin
				valve_d = VALVE_OPEN;
				cmd_d   = CMD_OPEN;
			end else begin
				open_cnt_d = open_inc;
				if (open_past) begin
					valve_d = VALVE_OPEN;
					cmd_d   = CMD_OPEN;
				end
			end
		end else begin
			open_cnt_d = '0;
			if (valve_q == VALVE_CLOSE || close_past) begin
				valve_d = VALVE_CLOSE;
				// drive closed only while the machine is idle
				cmd_d   = idle_s1 ? CMD_CLOSE : CMD_NONE;
			end
			if (valve_q != VALVE_CLOSE) begin
				close_cnt_d = close_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valve_q     <= VALVE_NULL;
			open_cnt_q  <= '0;
			close_cnt_q <= '0;
		end else if (advance) begin
			valve_q     <= valve_d;
			open_cnt_q  <= open_cnt_d;
			close_cnt_q <= close_cnt_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= advance || (out_valid && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ele_key_status <= ele_res.mode;
			res_key_status <= res_res.mode;
			valve_status   <= valve_d;
			valve_command  <= cmd_d;
			beep_request   <= ele_res.entered_down || res_res.entered_down;
		end
	end

	// checks
	`KVQ_ASSERT(a_beep_means_down, clk, arst_n,
		(out_valid && beep_request) |->
		(ele_key_status == KEY_DOWN || res_key_status == KEY_DOWN))
	`KVQ_ASSERT(a_cmd_matches_status, clk, arst_n,
		(out_valid && valve_command != CMD_NONE) |->
		((valve_command == CMD_OPEN && valve_status == VALVE_OPEN) ||
		(valve_command == CMD_CLOSE && valve_status == VALVE_CLOSE)))
	`KVQ_ASSERT_NEVER(a_one_valve_counter, clk, arst_n, open_cnt_q != '0 && close_cnt_q != '0)
	`KVQ_ASSERT(a_stalled_tick_kept, clk, arst_n, (v_s1 && !advance) |=> v_s1)

endmodule

[verif/tb_key_and_valve_input_qualifier_unit.sv]
// ---------------------------------------------------------------------------
// tb_key_and_valve_input_qualifier_unit
// Self-checking bench for the key and valve input qualifier. A short
// directed table, with some results typed in, is followed by random
// run-length stimulus over several threshold settings and a short pass
// with thresholds at the top of the range. Each result is checked against its
// typed value or a local behavioral predictor, mostly while both handshake sides idle and stall.
// ---------------------------------------------------------------------------
module tb_key_and_valve_input_qualifier_unit;
	import kvq_pkg::*;

	localparam int unsigned SETTLE_CYCLES    = 4;
	localparam int unsigned LONG_HOLD_CYCLES = 60;
	localparam int unsigned RANDOM_PHASES    = 4;
	localparam int unsigned PHASE_TICKS      = 100;
	localparam int unsigned TOP_LIMIT_TICKS  = 20;
	localparam int unsigned REPORT_LIMIT     = 10;

	localparam logic [CFG_IDX_W-1:0] REG_PAST_LAST = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;

	typedef logic [COUNTER_BITS_D-1:0] tick_cnt_t;

	typedef struct packed {
		logic ele;
		logic res;
		logic open_sig;
		logic idle;
	} tick_t;

	typedef struct packed {
		key_mode_t   ele;
		key_mode_t   res;
		valve_mode_t valve;
		valve_cmd_t  cmd;
		logic        beep;
	} qual_res_t;

	typedef enum logic {
		ROW_TICK,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [TICK_W-1:0]     wdata;
		tick_t                 stim;
		logic                  typed;
		qual_res_t             res;
	} stim_row_t;

	localparam qual_res_t RES_QUIET = '{KEY_UP, KEY_UP, VALVE_NULL, CMD_NONE, 1'b0};

	localparam int unsigned DIR_ROWS = 23;

	// stim bits: ele, res, open signal, idle
	stim_row_t dir_rows [DIR_ROWS] = '{
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0000, 1'b1, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1111, 1'b1, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_CFG,  REG_FILTER_TICKS, 16'd0, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_CFG,  REG_LONG_TICKS,   16'd1, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_CFG,  REG_OPEN_TICKS,   16'd0, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_CFG,  REG_CLOSE_TICKS,  16'd0, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1010, 1'b1, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1010, 1'b1,
			'{KEY_DOWN, KEY_UP, VALVE_OPEN, CMD_OPEN, 1'b1}},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1110, 1'b1,
			'{KEY_HOLD, KEY_UP, VALVE_OPEN, CMD_OPEN, 1'b0}},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1100, 1'b1,
			'{KEY_HOLD, KEY_DOWN, VALVE_NULL, CMD_NONE, 1'b1}},
		// close confirmed while the machine is busy: no drive
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0100, 1'b1,
			'{KEY_UP, KEY_HOLD, VALVE_CLOSE, CMD_NONE, 1'b0}},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0001, 1'b1,
			'{KEY_UP, KEY_UP, VALVE_CLOSE, CMD_CLOSE, 1'b0}},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0011, 1'b1, RES_QUIET},
		// threshold at the counter maximum, then writes to unused indexes
		'{ROW_CFG,  REG_FILTER_TICKS, 16'hFFFF, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_CFG,  REG_PAST_LAST,    16'h0000, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_CFG,  REG_TOP_INDEX,    16'hFFFF, 4'b0000, 1'b0, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1000, 1'b0, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1101, 1'b0, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b1101, 1'b0, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0110, 1'b0, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0001, 1'b0, RES_QUIET},
		'{ROW_TICK, REG_FILTER_TICKS, 16'd0, 4'b0000, 1'b0, RES_QUIET}
	};

	logic                 clk;
	logic                 arst_n            = 1'b0;
	logic                 in_valid          = 1'b0;
	logic                 in_ready;
	logic                 ele_pressed       = 1'b0;
	logic                 res_pressed       = 1'b0;
	logic                 valve_open_signal = 1'b0;
	logic                 machine_idle      = 1'b0;
	logic                 out_valid;
	logic                 out_ready         = 1'b0;
	logic [1:0]           ele_key_status;
	logic [1:0]           res_key_status;
	logic [1:0]           valve_status;
	logic [1:0]           valve_command;
	logic                 beep_request;
	logic                 cfg_valid         = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index         = '0;
	logic [TICK_W-1:0]    cfg_data          = '0;

	// predictor state and thresholds
	key_mode_t         ele_mode_q, res_mode_q;
	valve_mode_t       valve_mode_q;
	tick_cnt_t         ele_cnt_q, res_cnt_q, open_cnt_q, close_cnt_q;
	logic [TICK_W-1:0] filter_lim, long_lim, open_lim, close_lim;

	qual_res_t   status_exp_q [$];
	qual_res_t   got_res, exp_res;

	logic        gaps_on       = 1'b1;
	logic        long_hold_req = 1'b0;
	int unsigned src_burst     = 0;
	int unsigned snk_burst     = 0;
	logic [3:0]  run_lvl       = '0;
	int unsigned run_left [4]  = '{0, 0, 0, 0};
	int unsigned run_max       = 4;

	int unsigned n_ticks = 0, n_results = 0, n_writes = 0, n_errors = 0;
	int unsigned n_beeps = 0, n_holds = 0, n_open_drv = 0, n_close_drv = 0, n_busy = 0;

	key_and_valve_input_qualifier_unit i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.ele_pressed       (ele_pressed),
		.res_pressed       (res_pressed),
		.valve_open_signal (valve_open_signal),
		.machine_idle      (machine_idle),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.ele_key_status    (ele_key_status),
		.res_key_status    (res_key_status),
		.valve_status      (valve_status),
		.valve_command     (valve_command),
		.beep_request      (beep_request),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int unsigned draw_gap(inout int unsigned burst);
		if (!gaps_on)
			return 0;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			burst = $urandom_range(4, 24);
		return $urandom_range(0, 11);
	endfunction

	task automatic qualify_key(input logic pressed, inout key_mode_t mode,
			inout tick_cnt_t cnt, output logic entered);
		logic past;
		entered = 1'b0;
		if (!pressed) begin
			mode = KEY_UP;
			cnt  = '0;
		end else if (mode != KEY_HOLD) begin
			// compare the old count, then advance with saturation
			past = (mode == KEY_DOWN) ? (cnt > long_lim) : (cnt > filter_lim);
			if (cnt != '1)
				cnt = cnt + 1'b1;
			if (past) begin
				entered = (mode == KEY_UP);
				mode    = (mode == KEY_UP) ? KEY_DOWN : KEY_HOLD;
			end
		end
	endtask

	task automatic qualify_tick(input tick_t t, output qual_res_t r);
		logic ele_in, res_in, past;
		r = RES_QUIET;
		qualify_key(t.ele, ele_mode_q, ele_cnt_q, ele_in);
		qualify_key(t.res, res_mode_q, res_cnt_q, res_in);
		if (t.open_sig) begin
			close_cnt_q = '0;
			if (valve_mode_q != VALVE_OPEN) begin
				past = open_cnt_q > open_lim;
				if (open_cnt_q != '1)
					open_cnt_q = open_cnt_q + 1'b1;
				valve_mode_q = past ? VALVE_OPEN : VALVE_NULL;
			end
			if (valve_mode_q == VALVE_OPEN)
				r.cmd = CMD_OPEN;
		end else begin
			open_cnt_q = '0;
			if (valve_mode_q != VALVE_CLOSE) begin
				past = close_cnt_q > close_lim;
				if (close_cnt_q != '1)
					close_cnt_q = close_cnt_q + 1'b1;
				valve_mode_q = past ? VALVE_CLOSE : VALVE_NULL;
			end
			// a busy machine keeps the valve undriven
			if (valve_mode_q == VALVE_CLOSE && t.idle)
				r.cmd = CMD_CLOSE;
		end
		r.ele   = ele_mode_q;
		r.res   = res_mode_q;
		r.valve = valve_mode_q;
		r.beep  = ele_in | res_in;
	endtask

	task automatic send_tick(input tick_t t, input logic typed, input qual_res_t typed_res);
		int unsigned gap;
		qual_res_t   pred;
		gap = draw_gap(src_burst);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid          <= 1'b1;
		ele_pressed       <= t.ele;
		res_pressed       <= t.res;
		valve_open_signal <= t.open_sig;
		machine_idle      <= t.idle;
		do @(posedge clk); while (!in_ready);
		qualify_tick(t, pred);
		status_exp_q.push_back(typed ? typed_res : pred);
		n_ticks++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] wdata);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= wdata;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FILTER_TICKS: filter_lim = wdata;
			REG_LONG_TICKS:   long_lim   = wdata;
			REG_OPEN_TICKS:   open_lim   = wdata;
			REG_CLOSE_TICKS:  close_lim  = wdata;
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drop valid and wait until every expected result is back
	task automatic drain(input int unsigned extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (status_exp_q.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	// runs of random length per signal, with some noise ticks mixed in
	task automatic random_tick(output tick_t t);
		logic [3:0] lv;
		for (int i = 0; i < 4; i++) begin
			if (run_left[i] == 0) begin
				run_lvl[i]  = 1'($urandom_range(0, 1));
				run_left[i] = $urandom_range(1, run_max);
			end
			run_left[i]--;
			lv[i] = run_lvl[i];
		end
		if ($urandom_range(0, 99) < 15)
			lv = 4'($urandom_range(0, 15));
		t = lv;
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin : result_sink
		int unsigned hold;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			hold = draw_gap(snk_burst);
			if (long_hold_req) begin
				hold          = LONG_HOLD_CYCLES;
				long_hold_req = 1'b0;
			end
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got_res = '{key_mode_t'(ele_key_status), key_mode_t'(res_key_status),
				valve_mode_t'(valve_status), valve_cmd_t'(valve_command), beep_request};
			n_results++;
			n_beeps     += got_res.beep;
			n_holds     += (got_res.ele == KEY_HOLD || got_res.res == KEY_HOLD);
			n_open_drv  += (got_res.cmd == CMD_OPEN);
			n_close_drv += (got_res.cmd == CMD_CLOSE);
			n_busy      += (got_res.valve == VALVE_CLOSE && got_res.cmd == CMD_NONE);
			if (status_exp_q.size() == 0) begin
				n_errors++;
				if (n_errors <= REPORT_LIMIT)
					$display("unexpected result %0d: ele %0d res %0d valve %0d cmd %0d beep %0d",
						n_results, got_res.ele, got_res.res, got_res.valve, got_res.cmd,
						got_res.beep);
			end else begin
				exp_res = status_exp_q.pop_front();
				if (got_res.ele !== exp_res.ele || got_res.res !== exp_res.res ||
						got_res.valve !== exp_res.valve || got_res.cmd !== exp_res.cmd ||
						got_res.beep !== exp_res.beep) begin
					n_errors++;
					if (n_errors <= REPORT_LIMIT) begin
						$display("mismatch at result %0d: expected ele %0d res %0d valve %0d",
							n_results, exp_res.ele, exp_res.res, exp_res.valve);
						$display("  expected cmd %0d beep %0d, got ele %0d res %0d",
							exp_res.cmd, exp_res.beep, got_res.ele, got_res.res);
						$display("  got valve %0d cmd %0d beep %0d",
							got_res.valve, got_res.cmd, got_res.beep);
					end
				end
			end
		end
	end

	initial begin
		tick_t t;
		ele_mode_q   = KEY_UP;
		res_mode_q   = KEY_UP;
		valve_mode_q = VALVE_NULL;
		ele_cnt_q    = '0;
		res_cnt_q    = '0;
		open_cnt_q   = '0;
		close_cnt_q  = '0;
		filter_lim   = FILTER_TICKS_RST;
		long_lim     = LONG_TICKS_RST;
		open_lim     = OPEN_TICKS_RST;
		close_lim    = CLOSE_TICKS_RST;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				drain(SETTLE_CYCLES);
				write_reg(dir_rows[r].idx, dir_rows[r].wdata);
			end else begin
				send_tick(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].res);
			end
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain(SETTLE_CYCLES);
			case (ph)
				0: begin
					write_reg(REG_FILTER_TICKS, 16'd0);
					write_reg(REG_LONG_TICKS, 16'd0);
					write_reg(REG_OPEN_TICKS, 16'd0);
					write_reg(REG_CLOSE_TICKS, 16'd0);
					run_max = 6;
				end
				1: begin
					write_reg(REG_FILTER_TICKS, TICK_W'($urandom_range(0, 3)));
					write_reg(REG_LONG_TICKS, TICK_W'($urandom_range(0, 6)));
					write_reg(REG_OPEN_TICKS, TICK_W'($urandom_range(0, 4)));
					write_reg(REG_CLOSE_TICKS, TICK_W'($urandom_range(0, 4)));
					run_max = 10;
				end
				2: begin
					write_reg(REG_FILTER_TICKS, TICK_W'($urandom_range(2, 8)));
					write_reg(REG_LONG_TICKS, TICK_W'($urandom_range(5, 25)));
					write_reg(REG_OPEN_TICKS, TICK_W'($urandom_range(3, 12)));
					write_reg(REG_CLOSE_TICKS, TICK_W'($urandom_range(3, 12)));
					run_max = 30;
				end
				default: begin
					write_reg(REG_FILTER_TICKS, FILTER_TICKS_RST);
					write_reg(REG_LONG_TICKS, TICK_W'($urandom_range(10, 40)));
					write_reg(REG_OPEN_TICKS, OPEN_TICKS_RST);
					write_reg(REG_CLOSE_TICKS, CLOSE_TICKS_RST);
					run_max = 60;
				end
			endcase
			for (int k = 0; k < PHASE_TICKS; k++) begin
				// fill the pipeline against a stalled receiver
				if (ph == 1 && k == 30) begin
					long_hold_req = 1'b1;
					src_burst     = 24;
				end
				if (ph == 2 && k == 50)
					drain(0);
				random_tick(t);
				send_tick(t, 1'b0, RES_QUIET);
			end
		end

		// hold both keys and the open signal against long-press and open thresholds at the maximum
		drain(SETTLE_CYCLES);
		gaps_on = 1'b0;
		write_reg(REG_FILTER_TICKS, 16'd0);
		write_reg(REG_LONG_TICKS, 16'hFFFF);
		write_reg(REG_OPEN_TICKS, 16'hFFFF);
		for (int k = 0; k < TOP_LIMIT_TICKS; k++) begin
			t = {3'b111, 1'($urandom_range(0, 1))};
			send_tick(t, 1'b0, RES_QUIET);
		end
		drain(SETTLE_CYCLES);
		write_reg(REG_LONG_TICKS, 16'd65534);
		write_reg(REG_OPEN_TICKS, 16'd65534);
		write_reg(REG_CLOSE_TICKS, 16'd65534);
		write_reg(REG_FILTER_TICKS, 16'd65534);
		gaps_on = 1'b1;
		for (int k = 0; k < 6; k++) begin
			t = {2'b11, k < 3, 1'b1};
			send_tick(t, 1'b0, RES_QUIET);
		end

		drain(8);
		$display("Run drove %0d ticks through %0d register writes and compared %0d results.",
			n_ticks, n_writes, n_results);
		$display("Results held %0d beeps, %0d holds, %0d/%0d open/close drives, %0d busy.",
			n_beeps, n_holds, n_open_drv, n_close_drv, n_busy);
		if (n_errors == 0 && status_exp_q.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
